// ----- rtl/core/omp_pkg.sv -----
// ----------------------------------------------------------------------------
// omp_pkg
// Shared types and constants of the ordered max product matching block.
// ----------------------------------------------------------------------------
package omp_pkg;

  localparam int VALUE_BITS      = 16;
  localparam int MAX_FIRST_DEF   = 64;
  localparam int SUM_OUT_W       = 38;
  localparam int FIRST_CNT_W     = 7;
  localparam int SECOND_CNT_W    = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COUNT = 1'd1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_STREAM = 1'b1
  } omp_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INFEASIBLE = 2'd1,
    ST_ORDER      = 2'd2
  } omp_status_e;

  typedef struct packed {
    omp_op_e                       operation;
    logic signed [VALUE_BITS-1:0]  value;
  } omp_req_t;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0]   best_sum;
    omp_status_e                   status;
  } omp_res_t;

  // controls broadcast along the row of cells
  typedef struct packed {
    logic mul;
    logic upd;
    logic clr;
  } omp_cell_ctrl_t;

endpackage

// ----- rtl/core/omp_cell.sv -----
// ----------------------------------------------------------------------------
// omp_cell
// One row of the running best sums: holds one first value, multiplies it by
// the slot value, then folds the product onto the neighbor's best sum.
// ----------------------------------------------------------------------------
module omp_cell #(
  parameter int SUM_W = 2 * omp_pkg::VALUE_BITS + 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  omp_pkg::omp_cell_ctrl_t              ctrl_i,
  input  logic                                 load_i,
  input  logic signed [omp_pkg::VALUE_BITS-1:0] value_i,
  input  logic signed [SUM_W-1:0]              prev_best_i,
  input  logic                                 prev_valid_i,
  output logic signed [SUM_W-1:0]              best_o,
  output logic                                 valid_o
);

  localparam int PROD_W = 2 * omp_pkg::VALUE_BITS;

  logic signed [omp_pkg::VALUE_BITS-1:0] fv_q;
  logic signed [PROD_W-1:0]              prod_q;
  logic signed [SUM_W-1:0]               best_q, best_d, cand;
  logic                                  valid_q, valid_d, take;

  always_comb begin
    cand   = prev_best_i + SUM_W'(prod_q);
    take   = ctrl_i.upd && prev_valid_i && (!valid_q || (cand > best_q));
    best_d = take ? cand : best_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.upd && prev_valid_i) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fv_q <= value_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= fv_q * value_i;
    end
    best_q <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign best_o  = best_q;
  assign valid_o = valid_q;

endmodule

// ----- rtl/core/ordered_max_product_matching.sv -----
// ----------------------------------------------------------------------------
// ordered_max_product_matching
// Best order-preserving assignment of first values to slot values, scored by
// the sum of pairwise products, computed by a row of cells.
// ----------------------------------------------------------------------------
// One request is taken every cycle (busy stays low). A request that produces a
// result, the last slot value of a job or a request out of order, shows it on
// res_o with result_valid_o high for one cycle, after the per-cell multiply
// register, the cell update and the registered read of the selected row.
// Results cannot be held off.
module ordered_max_product_matching #(
  parameter int MAX_FIRST = omp_pkg::MAX_FIRST_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  omp_pkg::omp_req_t                  req_i,
  input  logic                               cfg_we_i,
  input  logic [omp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [omp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               result_valid_o,
  output omp_pkg::omp_res_t                  res_o
);

  localparam int SUM_W = 2 * omp_pkg::VALUE_BITS + $clog2(MAX_FIRST);
  localparam int CNT_W = $clog2(MAX_FIRST + 1);
  localparam int IDX_W = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
  localparam int FC_W  = omp_pkg::FIRST_CNT_W;
  localparam int SC_W  = omp_pkg::SECOND_CNT_W;

  logic [FC_W-1:0]  first_count_q;
  logic [SC_W-1:0]  second_count_q;
  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [SC_W-1:0]  streamed_q, streamed_d;

  logic [CNT_W-1:0] m_eff, m_minus;
  logic [SC_W-1:0]  n_eff;
  logic [SC_W:0]    j_next;
  logic             acc, is_stream, load_ok, stream_ok, err, last;

  logic                     s1_vld_q, s1_stream_q, s1_last_q;
  omp_pkg::omp_status_e     s1_status_q, s2_status_q, st_d;
  logic [IDX_W-1:0]         s1_idx_q, s2_idx_q;
  logic                     s2_vld_q;
  logic                     res_vld_q;
  omp_pkg::omp_res_t        res_q;

  omp_pkg::omp_cell_ctrl_t  cell_ctrl;
  logic signed [SUM_W-1:0]  best_w [MAX_FIRST];
  logic                     valid_w [MAX_FIRST];
  logic signed [SUM_W-1:0]  best_sel;
  logic                     thermo_ok;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= FC_W'(1);
      second_count_q <= SC_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        omp_pkg::CFG_FIRST_COUNT:  first_count_q  <= cfg_data_i[FC_W-1:0];
        omp_pkg::CFG_SECOND_COUNT: second_count_q <= cfg_data_i[SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (first_count_q == '0) begin
      m_eff = CNT_W'(1);
    end else if (32'(first_count_q) > 32'(MAX_FIRST)) begin
      m_eff = CNT_W'(MAX_FIRST);
    end else begin
      m_eff = CNT_W'(first_count_q);
    end
    m_minus = m_eff - CNT_W'(1);
    n_eff   = (second_count_q == '0) ? SC_W'(1) : second_count_q;

    acc       = start && !busy;
    is_stream = (req_i.operation == omp_pkg::OP_STREAM);
    load_ok   = acc && !is_stream && (loaded_q < m_eff) && (streamed_q == '0);
    stream_ok = acc && is_stream && (loaded_q >= m_eff);
    err       = acc && !load_ok && !stream_ok;
    j_next    = {1'b0, streamed_q} + (SC_W + 1)'(1);
    last      = stream_ok && (j_next >= {1'b0, n_eff});

    loaded_d   = loaded_q;
    streamed_d = streamed_q;
    if (last) begin
      loaded_d   = '0;
      streamed_d = '0;
    end else begin
      if (stream_ok) begin
        streamed_d = j_next[SC_W-1:0];
      end
      if (load_ok) begin
        loaded_d = loaded_q + CNT_W'(1);
      end
    end

    if (err) begin
      st_d = omp_pkg::ST_ORDER;
    end else if (32'(m_eff) > 32'(n_eff)) begin
      st_d = omp_pkg::ST_INFEASIBLE;
    end else begin
      st_d = omp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      streamed_q  <= '0;
      s1_vld_q    <= 1'b0;
      s1_stream_q <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      streamed_q  <= streamed_d;
      s1_vld_q    <= err || last;
      s1_stream_q <= stream_ok;
      s1_last_q   <= last;
      s2_vld_q    <= s1_vld_q;
      res_vld_q   <= s2_vld_q;
    end
  end

  // result path payload
  always_ff @(posedge clk_i) begin
    s1_status_q <= st_d;
    s1_idx_q    <= m_minus[IDX_W-1:0];
    s2_status_q <= s1_status_q;
    s2_idx_q    <= s1_idx_q;
    res_q.status <= s2_status_q;
    if (s2_status_q == omp_pkg::ST_OK) begin
      res_q.best_sum <= omp_pkg::SUM_OUT_W'(best_sel);
    end else begin
      res_q.best_sum <= '0;
    end
  end

  assign cell_ctrl.mul = stream_ok;
  assign cell_ctrl.upd = s1_stream_q;
  assign cell_ctrl.clr = s1_stream_q && s1_last_q;

  for (genvar r = 0; r < MAX_FIRST; r++) begin : g_row
    logic signed [SUM_W-1:0] prev_best;
    logic                    prev_valid;
    omp_pkg::omp_cell_ctrl_t row_ctrl;
    // rows above the first count take no update
    assign row_ctrl.mul = cell_ctrl.mul;
    assign row_ctrl.upd = cell_ctrl.upd && (IDX_W'(r) <= s1_idx_q);
    assign row_ctrl.clr = cell_ctrl.clr;
    if (r == 0) begin : g_head
      assign prev_best  = '0;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_best  = best_w[r-1];
      assign prev_valid = valid_w[r-1];
    end
    omp_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (row_ctrl),
      .load_i       (load_ok && (loaded_q == CNT_W'(r))),
      .value_i      (req_i.value),
      .prev_best_i  (prev_best),
      .prev_valid_i (prev_valid),
      .best_o       (best_w[r]),
      .valid_o      (valid_w[r])
    );
  end

  always_comb begin
    best_sel  = '0;
    thermo_ok = 1'b1;
    for (int r = 0; r < MAX_FIRST; r++) begin
      if (s2_idx_q == IDX_W'(r)) begin
        best_sel = best_w[r];
      end
      if (r > 0 && valid_w[r] && !valid_w[r-1]) begin
        thermo_ok = 1'b0;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  // valid rows always form a prefix of the row of cells
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thermo_ok)
    else $error("row valid bits not contiguous");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 3))
    else $error("result without matching request");

  a_ok_from_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.status == omp_pkg::ST_OK)
      |-> $past(req_i.operation == omp_pkg::OP_STREAM, 3))
    else $error("ok result not caused by a slot value");

  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> (loaded_q == '0 && streamed_q == '0))
    else $error("job counts not cleared after last slot value");

endmodule

// ----- sim/tb_ordered_max_product_matching.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_max_product_matching
// Self-checking bench for the ordered max product matching block. A dynamic
// programming model kept in the bench predicts each best sum and status from
// the accepted requests. A monitor compares every result strobe against the
// oldest prediction. Directed jobs cover order errors, infeasible jobs, count
// saturation and the largest sizes. Random jobs follow, with random gaps and
// random count settings.
// ----------------------------------------------------------------------------
module tb_ordered_max_product_matching;

  localparam int    HALF_PERIOD  = 10;
  localparam int    RESET_CYCLES = 9;
  localparam int    PIPE_CYCLES  = 4;
  localparam int    RANDOM_ITEMS = 160;
  localparam longint TIMEOUT_NS  = 10_000_000;

  logic                                clk_i      = 1'b0;
  logic                                rst_ni     = 1'b0;
  logic                                start      = 1'b0;
  logic                                busy;
  omp_pkg::omp_req_t                   req_i      = '0;
  logic                                cfg_we_i   = 1'b0;
  logic [omp_pkg::CFG_IDX_W-1:0]       cfg_idx_i  = '0;
  logic [omp_pkg::CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                                result_valid_o;
  omp_pkg::omp_res_t                   res_o;

  ordered_max_product_matching dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // bench copy of the matching state
  logic [omp_pkg::FIRST_CNT_W-1:0]  first_reg  = 7'd1;
  logic [omp_pkg::SECOND_CNT_W-1:0] second_reg = 16'd1;
  longint                  first_vals [omp_pkg::MAX_FIRST_DEF];
  longint                  row_best   [omp_pkg::MAX_FIRST_DEF];
  bit                      row_ok     [omp_pkg::MAX_FIRST_DEF];
  int                      n_loaded   = 0;
  int                      n_streamed = 0;

  omp_pkg::omp_res_t awaited_results[$];

  int  failures   = 0;
  int  items_sent = 0;
  int  reg_writes = 0;
  int  seen_ok    = 0;
  int  seen_infeasible = 0;
  int  seen_order = 0;
  bit  no_gaps    = 1'b0;

  function automatic int eff_first();
    if (first_reg < 1) return 1;
    if (first_reg > omp_pkg::MAX_FIRST_DEF) return omp_pkg::MAX_FIRST_DEF;
    return int'(first_reg);
  endfunction

  function automatic int eff_second();
    return (second_reg == 0) ? 1 : int'(second_reg);
  endfunction

  function automatic logic signed [omp_pkg::VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1: return 16'(signed'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void clear_job();
    n_loaded   = 0;
    n_streamed = 0;
    foreach (row_ok[i]) row_ok[i] = 1'b0;
  endfunction

  // one request through the row update: best[i] = max(best[i], best[i-1] + v[i]*c)
  function automatic void match_dp_step(omp_pkg::omp_req_t r);
    int                m;
    int                n;
    int                j;
    int                top;
    longint            slot;
    longint            prev;
    longint            cand;
    omp_pkg::omp_res_t res;
    m    = eff_first();
    n    = eff_second();
    slot = longint'(r.value);
    res  = '0;
    if (r.operation == omp_pkg::OP_LOAD) begin
      if (n_loaded >= m || n_streamed != 0) begin
        res.status = omp_pkg::ST_ORDER;
        awaited_results.push_back(res);
      end else begin
        first_vals[n_loaded] = slot;
        n_loaded++;
      end
    end else if (n_loaded < m) begin
      res.status = omp_pkg::ST_ORDER;
      awaited_results.push_back(res);
    end else begin
      j   = n_streamed + 1;
      top = (j < m) ? j : m;
      for (int i = top; i >= 1; i--) begin
        if (i == 1) prev = 0;
        else if (row_ok[i-2]) prev = row_best[i-2];
        else continue;
        cand = prev + first_vals[i-1] * slot;
        if (!row_ok[i-1] || cand > row_best[i-1]) row_best[i-1] = cand;
        row_ok[i-1] = 1'b1;
      end
      n_streamed = j;
      if (n_streamed >= n) begin
        if (m > n || !row_ok[m-1]) begin
          res.status = omp_pkg::ST_INFEASIBLE;
        end else begin
          res.status   = omp_pkg::ST_OK;
          res.best_sum = row_best[m-1][omp_pkg::SUM_OUT_W-1:0];
        end
        awaited_results.push_back(res);
        clear_job();
      end
    end
  endfunction

  task automatic send_request(input omp_pkg::omp_op_e op,
                              input logic signed [omp_pkg::VALUE_BITS-1:0] val);
    omp_pkg::omp_req_t r;
    int                gap;
    r.operation = op;
    r.value     = val;
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    match_dp_step(r);
    items_sent++;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0, 1:    gap = $urandom_range(4, 40);
        2, 3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every predicted result is in and the pipe has emptied
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [omp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [omp_pkg::CFG_DATA_W-1:0] data);
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    if (idx == omp_pkg::CFG_FIRST_COUNT) begin
      first_reg = data[omp_pkg::FIRST_CNT_W-1:0];
    end else if (idx == omp_pkg::CFG_SECOND_COUNT) begin
      second_reg = data[omp_pkg::SECOND_CNT_W-1:0];
    end
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    omp_pkg::omp_res_t want;
    if (rst_ni && result_valid_o) begin
      case (res_o.status)
        omp_pkg::ST_OK:         seen_ok++;
        omp_pkg::ST_INFEASIBLE: seen_infeasible++;
        default:                seen_order++;
      endcase
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: best_sum %0d status %0d",
               res_o.best_sum, res_o.status);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (res_o.best_sum !== want.best_sum) begin
          $error("best_sum: expected %0d, got %0d", want.best_sum, res_o.best_sum);
          failures++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          failures++;
        end
      end
    end
  end

  task automatic test_defaults_after_reset();
    send_request(omp_pkg::OP_STREAM, 16'sd7);
    send_request(omp_pkg::OP_LOAD, 16'sh8000);
    send_request(omp_pkg::OP_LOAD, 16'sd5);
    send_request(omp_pkg::OP_STREAM, 16'sh8000);
    settle();
  endtask

  task automatic test_out_of_order();
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'd2);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd3);
    send_request(omp_pkg::OP_LOAD, 16'sh7fff);
    send_request(omp_pkg::OP_STREAM, 16'sd3);
    send_request(omp_pkg::OP_LOAD, 16'sh8000);
    send_request(omp_pkg::OP_LOAD, 16'sd9);
    send_request(omp_pkg::OP_STREAM, 16'sh7fff);
    send_request(omp_pkg::OP_LOAD, 16'sd1);
    send_request(omp_pkg::OP_STREAM, 16'sh8000);
    send_request(omp_pkg::OP_STREAM, 16'sd0);
    settle();
  endtask

  task automatic test_infeasible_job();
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'd3);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd2);
    send_request(omp_pkg::OP_LOAD, 16'sd1);
    send_request(omp_pkg::OP_LOAD, -16'sd1);
    send_request(omp_pkg::OP_LOAD, 16'sh7fff);
    send_request(omp_pkg::OP_STREAM, 16'sd100);
    send_request(omp_pkg::OP_STREAM, -16'sd100);
    settle();
  endtask

  task automatic test_count_saturation();
    // low seven bits zero: used as one; zero slot count: used as one
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'hff80);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd0);
    send_request(omp_pkg::OP_LOAD, 16'sd100);
    send_request(omp_pkg::OP_STREAM, -16'sd200);
    settle();
  endtask

  task automatic test_max_sizes();
    no_gaps = 1'b1;
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'h007f);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd64);
    for (int k = 0; k < omp_pkg::MAX_FIRST_DEF; k++)
      send_request(omp_pkg::OP_LOAD, (k % 2 == 0) ? 16'sh8000 : 16'sh7fff);
    for (int k = 0; k < 64; k++)
      send_request(omp_pkg::OP_STREAM, (k % 3 == 0) ? 16'sh7fff : 16'sh8000);
    settle();
    no_gaps = 1'b0;
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'd64);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd65);
    for (int k = 0; k < omp_pkg::MAX_FIRST_DEF; k++)
      send_request(omp_pkg::OP_LOAD, rand_value());
    for (int k = 0; k < 65; k++) send_request(omp_pkg::OP_STREAM, rand_value());
    settle();
  endtask

  task automatic test_live_count_change();
    write_reg(omp_pkg::CFG_FIRST_COUNT, 16'd2);
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'hffff);
    send_request(omp_pkg::OP_LOAD, 16'sd11);
    send_request(omp_pkg::OP_LOAD, -16'sd13);
    for (int k = 0; k < 5; k++) send_request(omp_pkg::OP_STREAM, rand_value());
    settle();
    // slot count now below the streamed count: next slot value ends the job
    write_reg(omp_pkg::CFG_SECOND_COUNT, 16'd3);
    send_request(omp_pkg::OP_STREAM, 16'sd21);
    settle();
  endtask

  task automatic test_random_jobs();
    int base;
    int m;
    int n;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 19))
          0:       m = $urandom_range(33, 64);
          1, 2, 3, 4, 5: m = $urandom_range(7, 20);
          default: m = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(m + 9, m + 40);
          1, 2:    n = (m > 1) ? $urandom_range(1, m - 1) : m;
          default: n = $urandom_range(m, m + 8);
        endcase
        settle();
        write_reg(omp_pkg::CFG_FIRST_COUNT, {9'($urandom), 7'(m)});
        write_reg(omp_pkg::CFG_SECOND_COUNT, 16'(n));
      end
      m = eff_first();
      n = eff_second();
      for (int k = 0; k < m; k++) begin
        if ($urandom_range(0, 19) == 0) send_request(omp_pkg::OP_STREAM, rand_value());
        send_request(omp_pkg::OP_LOAD, rand_value());
      end
      if ($urandom_range(0, 9) == 0) send_request(omp_pkg::OP_LOAD, rand_value());
      for (int k = 0; k < n; k++) begin
        if (k > 0 && $urandom_range(0, 19) == 0) begin
          send_request(omp_pkg::OP_LOAD, rand_value());
        end
        send_request(omp_pkg::OP_STREAM, rand_value());
      end
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    clear_job();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_after_reset();
    test_out_of_order();
    test_infeasible_job();
    test_count_saturation();
    test_max_sizes();
    test_live_count_change();
    test_random_jobs();
    repeat (2 * PIPE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      failures++;
    end
    $display("requests sent: %0d, register writes: %0d", items_sent, reg_writes);
    $display("results seen: %0d ok, %0d infeasible, %0d out of order",
             seen_ok, seen_infeasible, seen_order);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $error("timeout with %0d results outstanding", awaited_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
